### rtl/core/decimal_text_to_double_defines.svh
// ----------------------------------------------------------------------------
// Decimal text to double: assertion macros
// Shared assertion forms clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_DOUBLE_DEFINES_SVH
`define DECIMAL_TEXT_TO_DOUBLE_DEFINES_SVH

// check in the same cycle
`define DTD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// check in the next cycle
`define DTD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/dtd_pkg.sv
// ----------------------------------------------------------------------------
// Decimal text to double: package
// Phase codes, character codes, scaling constants and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtd_pkg;

    localparam int EXP_DIGITS_W  = 14;
    localparam int EXP_LIMIT_DEF = 9999;
    localparam int DEC_EXP_W     = 16;
    localparam int SCALE_EXP_W   = 18;

    localparam logic [2:0] PH_INT   = 3'd0;
    localparam logic [2:0] PH_FRAC  = 3'd1;
    localparam logic [2:0] PH_ESIGN = 3'd2;
    localparam logic [2:0] PH_EDIG  = 3'd3;
    localparam logic [2:0] PH_STOP  = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [52:0] K_TEN_MANT   = 53'h14000000000000;
    localparam logic [52:0] K_TENTH_MANT = 53'h1999999999999A;

    localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
    localparam logic [63:0] DBL_INF      = 64'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic start;
        logic tenth;
    } dtd_mul_ctl_t;

    function automatic logic [63:0] digit_double(input logic [3:0] d);
        logic [63:0] r;
        case (d)
            4'd0:    r = 64'h0000_0000_0000_0000;
            4'd1:    r = 64'h3FF0_0000_0000_0000;
            4'd2:    r = 64'h4000_0000_0000_0000;
            4'd3:    r = 64'h4008_0000_0000_0000;
            4'd4:    r = 64'h4010_0000_0000_0000;
            4'd5:    r = 64'h4014_0000_0000_0000;
            4'd6:    r = 64'h4018_0000_0000_0000;
            4'd7:    r = 64'h401C_0000_0000_0000;
            4'd8:    r = 64'h4020_0000_0000_0000;
            4'd9:    r = 64'h4022_0000_0000_0000;
            default: r = 64'h0000_0000_0000_0000;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/dtd_fmul.sv
// ----------------------------------------------------------------------------
// Decimal text to double: shared multiplier
// Multiplies a non-negative double by 10.0 or 0.1 with round-to-nearest-even,
// summing four 53x14 partial products in turn, then a round and pack step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtd_fmul (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dtd_pkg::dtd_mul_ctl_t ctl,
    input  logic [63:0]          operand,
    output logic                 done,
    output logic [63:0]          result
);
    import dtd_pkg::*;

    localparam int CHUNK_W  = 14;
    localparam int N_CHUNKS = 4;
    localparam int PAD_W    = CHUNK_W * N_CHUNKS;

    logic               run_reg, run_next;
    logic               pack_reg, pack_next;
    logic               done_reg, done_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               tenth_reg, tenth_next;
    logic               zero_reg, zero_next;
    logic               inf_reg, inf_next;
    logic [52:0]        mant_reg, mant_next;
    logic signed [12:0] exp_reg, exp_next;
    logic [105:0]       prod_reg, prod_next;
    logic [63:0]        res_reg, res_next;

    logic [10:0]        op_field;
    logic [PAD_W-1:0]   kpad;
    logic [CHUNK_W-1:0] chunk;
    logic [66:0]        pp;
    logic signed [12:0] kexp;
    logic signed [12:0] er;
    logic signed [12:0] field_n;
    logic signed [12:0] sub_s;
    logic               normal_out;
    logic [6:0]         sh;
    logic [105:0]       kept_w;
    logic [105:0]       g_w;
    logic [105:0]       mask;
    logic               sticky;
    logic               rnd;
    logic [10:0]        fld;
    logic [63:0]        packed_bits;

    assign op_field = operand[62:52];
    assign kpad     = PAD_W'(tenth_reg ? K_TENTH_MANT : K_TEN_MANT);
    assign chunk    = kpad[cnt_reg*CHUNK_W +: CHUNK_W];
    assign pp       = 67'(mant_reg) * 67'(chunk);

    always_comb begin
        kexp        = tenth_reg ? -13'sd4 : 13'sd3;
        er          = exp_reg + kexp + (prod_reg[105] ? 13'sd1 : 13'sd0);
        field_n     = er + 13'sd1023;
        normal_out  = mant_reg[52] && (er >= -13'sd1022);
        sub_s       = -exp_reg - kexp - 13'sd970;
        sh          = normal_out ? (prod_reg[105] ? 7'd53 : 7'd52) : sub_s[6:0];
        kept_w      = prod_reg >> sh;
        g_w         = prod_reg >> (sh - 7'd1);
        mask        = (106'(1) << (sh - 7'd1)) - 106'(1);
        sticky      = |(prod_reg & mask);
        rnd         = g_w[0] & (sticky | kept_w[0]);
        fld         = normal_out ? field_n[10:0] : 11'd0;
        packed_bits = {1'b0, fld, kept_w[51:0]} + 64'(rnd);
    end

    always_comb begin
        run_next   = run_reg;
        pack_next  = 1'b0;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        tenth_next = tenth_reg;
        zero_next  = zero_reg;
        inf_next   = inf_reg;
        mant_next  = mant_reg;
        exp_next   = exp_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        if (ctl.start) begin
            run_next   = 1'b1;
            cnt_next   = 2'd0;
            tenth_next = ctl.tenth;
            zero_next  = (operand[62:0] == 63'd0);
            inf_next   = (op_field == EXP_ALL_ONES);
            mant_next  = {(op_field != 11'd0), operand[51:0]};
            exp_next   = (op_field == 11'd0) ? -13'sd1022
                                             : $signed({2'b00, op_field}) - 13'sd1023;
            prod_next  = '0;
        end else if (run_reg) begin
            prod_next = prod_reg + (106'(pp) << (CHUNK_W * cnt_reg));
            cnt_next  = cnt_reg + 2'd1;
            if (cnt_reg == 2'(N_CHUNKS - 1)) begin
                run_next  = 1'b0;
                pack_next = 1'b1;
            end
        end else if (pack_reg) begin
            done_next = 1'b1;
            if (zero_reg) begin
                res_next = '0;
            end else if (inf_reg || (normal_out && field_n >= 13'sd2047)) begin
                res_next = DBL_INF;
            end else begin
                res_next = packed_bits;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            pack_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            tenth_reg <= 1'b0;
            zero_reg  <= 1'b0;
            inf_reg   <= 1'b0;
        end else begin
            run_reg   <= run_next;
            pack_reg  <= pack_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            tenth_reg <= tenth_next;
            zero_reg  <= zero_next;
            inf_reg   <= inf_next;
        end
        mant_reg <= mant_next;
        exp_reg  <= exp_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### rtl/core/decimal_text_to_double.sv
// Flow: a mantissa digit item goes through the shared multiply, then the add;
// ready is low while an item is in work.
// A last item then runs the scaling: one multiply step per unit of the
// decimal exponent (up to 42767 steps, fewer once the value is zero or infinite),
// then the output register is loaded.
// Reset: synchronous, active low; clears the parse state to integer digits, +0.0.
// ----------------------------------------------------------------------------
// Decimal text to double: top level
// Parses ASCII decimal text one character per item and emits an IEEE double.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_text_to_double #(
    parameter int EXP_DIGIT_LIMIT = dtd_pkg::EXP_LIMIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value_bits
);
    import dtd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_SMUL  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic signed [DEC_EXP_W-1:0] DEC_EXP_MIN = {1'b1, {(DEC_EXP_W-1){1'b0}}};

    logic [2:0]                      state_reg, state_next;
    logic [2:0]                      phase_reg, phase_next;
    logic [63:0]                     acc_reg, acc_next;
    logic signed [DEC_EXP_W-1:0]     dec_exp_reg, dec_exp_next;
    logic [EXP_DIGITS_W-1:0]         exp_dig_reg, exp_dig_next;
    logic                            exp_neg_reg, exp_neg_next;
    logic [3:0]                      digit_reg, digit_next;
    logic                            last_reg, last_next;
    logic signed [SCALE_EXP_W-1:0]   scale_reg, scale_next;
    logic                            m_valid_reg, m_valid_next;
    logic [63:0]                     m_bits_reg, m_bits_next;

    logic                            accept;
    logic                            is_dig;
    logic                            is_e;
    logic [7:0]                      ch_off;
    logic [3:0]                      dval;
    logic [SCALE_EXP_W-1:0]          ev;
    logic [EXP_DIGITS_W-1:0]         ev_sat;
    logic                            acc_done;
    dtd_mul_ctl_t                    mul_ctl;
    logic                            mul_done;
    logic [63:0]                     mul_res;

    logic [63:0]                     dd;
    logic [10:0]                     et;
    logic [10:0]                     diff;
    logic [55:0]                     ma;
    logic [55:0]                     mb;
    logic [55:0]                     mb_sh;
    logic [55:0]                     mb_mask;
    logic [55:0]                     al;
    logic [56:0]                     sum;
    logic [55:0]                     sn;
    logic [11:0]                     f;
    logic                            inc;
    logic [63:0]                     add_res;

    dtd_fmul u_fmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .operand (acc_reg),
        .done    (mul_done),
        .result  (mul_res)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_dig   = s_ch inside {[CH_ZERO:CH_NINE]};
    assign is_e     = (s_ch == CH_E_LO) || (s_ch == CH_E_UP);
    assign ch_off   = s_ch - CH_ZERO;
    assign dval     = ch_off[3:0];
    assign ev       = (SCALE_EXP_W'(exp_dig_reg) << 3) + (SCALE_EXP_W'(exp_dig_reg) << 1)
                    + SCALE_EXP_W'(dval);
    assign ev_sat   = (ev > SCALE_EXP_W'(EXP_DIGIT_LIMIT)) ? EXP_DIGITS_W'(EXP_DIGIT_LIMIT)
                                                           : ev[EXP_DIGITS_W-1:0];
    assign acc_done = (acc_reg[62:0] == 63'd0) || (acc_reg[62:52] == EXP_ALL_ONES);

    // add digit to scaled accumulator
    always_comb begin
        dd      = digit_double(digit_reg);
        et      = mul_res[62:52];
        diff    = et - dd[62:52];
        ma      = {1'b1, mul_res[51:0], 3'b000};
        mb      = {1'b1, dd[51:0], 3'b000};
        mb_sh   = (diff >= 11'd56) ? 56'd0 : (mb >> diff);
        mb_mask = (diff >= 11'd56) ? {56{1'b1}} : ((56'(1) << diff) - 56'(1));
        al      = {mb_sh[55:1], mb_sh[0] | (|(mb & mb_mask))};
        sum     = {1'b0, ma} + {1'b0, al};
        if (sum[56]) begin
            sn = {sum[56:2], sum[1] | sum[0]};
            f  = {1'b0, et} + 12'd1;
        end else begin
            sn = sum[55:0];
            f  = {1'b0, et};
        end
        inc = sn[2] & (sn[3] | sn[1] | sn[0]);
        if (et == EXP_ALL_ONES) begin
            add_res = DBL_INF;
        end else if (mul_res[62:0] == 63'd0) begin
            add_res = dd;
        end else if (digit_reg == 4'd0) begin
            add_res = mul_res;
        end else if (f >= 12'd2047) begin
            add_res = DBL_INF;
        end else begin
            add_res = {1'b0, f[10:0], sn[54:3]} + 64'(inc);
        end
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        dec_exp_next  = dec_exp_reg;
        exp_dig_next  = exp_dig_reg;
        exp_neg_next  = exp_neg_reg;
        digit_next    = digit_reg;
        last_next     = last_reg;
        scale_next    = scale_reg;
        m_valid_next  = m_valid_reg;
        m_bits_next   = m_bits_reg;
        mul_ctl.start = 1'b0;
        mul_ctl.tenth = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    digit_next = dval;
                    last_next  = s_last;
                    case (phase_reg)
                        PH_INT: begin
                            if (is_dig) begin
                                mul_ctl.start = 1'b1;
                            end else if (s_ch == CH_DOT) begin
                                phase_next = PH_FRAC;
                            end else if (is_e) begin
                                phase_next = PH_ESIGN;
                            end else begin
                                phase_next = PH_STOP;
                            end
                        end
                        PH_FRAC: begin
                            if (is_dig) begin
                                mul_ctl.start = 1'b1;
                                if (dec_exp_reg != DEC_EXP_MIN) begin
                                    dec_exp_next = dec_exp_reg - $signed(DEC_EXP_W'(1));
                                end
                            end else if (is_e) begin
                                phase_next = PH_ESIGN;
                            end else begin
                                phase_next = PH_STOP;
                            end
                        end
                        PH_ESIGN: begin
                            if (s_ch == CH_PLUS) begin
                                phase_next = PH_EDIG;
                            end else if (s_ch == CH_MINUS) begin
                                exp_neg_next = 1'b1;
                                phase_next   = PH_EDIG;
                            end else if (is_dig) begin
                                exp_dig_next = ev_sat;
                                phase_next   = PH_EDIG;
                            end else begin
                                phase_next = PH_STOP;
                            end
                        end
                        PH_EDIG: begin
                            if (is_dig) begin
                                exp_dig_next = ev_sat;
                            end else begin
                                phase_next = PH_STOP;
                            end
                        end
                        default: begin
                            phase_next = PH_STOP;
                        end
                    endcase
                    if (mul_ctl.start) begin
                        state_next = S_MUL;
                    end else if (s_last) begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                acc_next   = add_res;
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (exp_neg_reg) begin
                    scale_next = SCALE_EXP_W'(dec_exp_reg) - $signed(SCALE_EXP_W'(exp_dig_reg));
                end else begin
                    scale_next = SCALE_EXP_W'(dec_exp_reg) + $signed(SCALE_EXP_W'(exp_dig_reg));
                end
                state_next = S_SCALE;
            end
            S_SCALE: begin
                if (scale_reg > 0 && !acc_done) begin
                    mul_ctl.start = 1'b1;
                    scale_next    = scale_reg - $signed(SCALE_EXP_W'(1));
                    state_next    = S_SMUL;
                end else if (scale_reg < 0 && !acc_done) begin
                    mul_ctl.start = 1'b1;
                    mul_ctl.tenth = 1'b1;
                    scale_next    = scale_reg + $signed(SCALE_EXP_W'(1));
                    state_next    = S_SMUL;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_SMUL: begin
                if (mul_done) begin
                    acc_next   = mul_res;
                    state_next = S_SCALE;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_bits_next  = acc_reg;
                    m_valid_next = 1'b1;
                    acc_next     = '0;
                    dec_exp_next = '0;
                    exp_dig_next = '0;
                    exp_neg_next = 1'b0;
                    phase_next   = PH_INT;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_INT;
            acc_reg     <= '0;
            dec_exp_reg <= '0;
            exp_dig_reg <= '0;
            exp_neg_reg <= 1'b0;
            last_reg    <= 1'b0;
            scale_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            dec_exp_reg <= dec_exp_next;
            exp_dig_reg <= exp_dig_next;
            exp_neg_reg <= exp_neg_next;
            last_reg    <= last_next;
            scale_reg   <= scale_next;
            m_valid_reg <= m_valid_next;
        end
        digit_reg  <= digit_next;
        m_bits_reg <= m_bits_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_value_bits = m_bits_reg;

endmodule

### rtl/core/dtd_checker.sv
// ----------------------------------------------------------------------------
// Decimal text to double: port checker
// Watches the top-level ports over time; bound to every instance of the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_text_to_double_defines.svh"

module dtd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_value_bits
);

    `DTD_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_value_bits), "result item changed while stalled")
    `DTD_ASSERT_NXT(a_last_busy, s_valid && s_ready && s_last, !s_ready, "ready stayed high after a last item")
    `DTD_ASSERT_IMP(a_sign_pos, m_valid, !m_value_bits[63], "negative result")
    `DTD_ASSERT_IMP(a_no_nan, m_valid, (m_value_bits[62:52] != 11'h7FF) || (m_value_bits[51:0] == 52'd0), "NaN result")

endmodule

bind decimal_text_to_double dtd_checker u_dtd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_last       (s_last),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_value_bits (m_value_bits)
);
